// ===== rtl/layer_clipped_weighted_centroid_core_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the layer clipped weighted centroid core
// Each macro expects clk and rst_n in the scope where it is used.
// ----------------------------------------------------------------------------
`ifndef LAYER_CLIPPED_WEIGHTED_CENTROID_CORE_MACROS_SVH
`define LAYER_CLIPPED_WEIGHTED_CENTROID_CORE_MACROS_SVH

// Same-cycle implication
`define LCWC_ASSERT_IMPLIES(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define LCWC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/lcwc_pkg.sv =====
// ----------------------------------------------------------------------------
// lcwc_pkg
// Shared types and constants of the layer clipped weighted centroid core.
// ----------------------------------------------------------------------------
package lcwc_pkg;

    localparam int COORD_BITS_DEF    = 20;
    localparam int FRACTION_BITS_DEF = 16;
    localparam int RADIUS_BITS       = 19;
    localparam int ENERGY_BITS       = 20;
    localparam int TIME_BITS         = 16;
    localparam int SUM_BITS          = 64;
    localparam int WEIGHT_BITS       = 48;
    localparam int INDEX_BITS        = 2;
    localparam int DIV_NUM_BITS      = 64;
    localparam int DIV_DEN_BITS      = WEIGHT_BITS + 1;

    // Configuration register indexes
    localparam logic [INDEX_BITS-1:0] REG_INNER_RADIUS = 2'd0;
    localparam logic [INDEX_BITS-1:0] REG_OUTER_RADIUS = 2'd1;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_RIN,
        ST_ROUT,
        ST_AX,
        ST_AY,
        ST_BX,
        ST_BY,
        ST_ORD,
        ST_CLS,
        ST_SRCH,
        ST_LX,
        ST_LY,
        ST_SQX,
        ST_SQY,
        ST_CMP,
        ST_SPAN,
        ST_W,
        ST_LRP,
        ST_LRA,
        ST_SW,
        ST_SWA,
        ST_TW,
        ST_TWA,
        ST_FIN,
        ST_DIV,
        ST_DWAIT,
        ST_OUT
    } lcwc_state_t;

endpackage

// ===== rtl/lcwc_div.sv =====
// ----------------------------------------------------------------------------
// lcwc_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module lcwc_div
    import lcwc_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic [DIV_NUM_BITS-1:0] dividend,
    input  logic [DIV_DEN_BITS-1:0] divisor,
    output logic                    done,
    output logic [DIV_NUM_BITS-1:0] quotient
);

    localparam int CNT_BITS = $clog2(DIV_NUM_BITS + 1);

    logic [DIV_DEN_BITS-1:0] rem_reg;
    logic [DIV_NUM_BITS-1:0] quo_reg;
    logic [CNT_BITS-1:0]     cnt_reg;
    logic                    run_reg;
    logic                    done_reg;
    logic [DIV_DEN_BITS:0]   trial;
    logic                    fits;

    // Shift in the next dividend bit and test against the divisor
    assign trial = {rem_reg, quo_reg[DIV_NUM_BITS-1]};
    assign fits  = trial >= {1'b0, divisor};

    // Control: bit counter and completion strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= CNT_BITS'(DIV_NUM_BITS);
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_BITS'(1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath: partial remainder and quotient shift register
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
        end
        else if (run_reg)
        begin
            rem_reg <= fits ? DIV_DEN_BITS'(trial - {1'b0, divisor})
                            : DIV_DEN_BITS'(trial);
            quo_reg <= {quo_reg[DIV_NUM_BITS-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ===== rtl/layer_clipped_weighted_centroid_core.sv =====
// ----------------------------------------------------------------------------
// layer_clipped_weighted_centroid_core
// Energy weighted centroid of cluster hits clipped to a radial layer.
// ----------------------------------------------------------------------------
// A hit transaction is taken when start is high and busy is low; busy stays
// high until the hit is handled and any result is out. A hit wholly under the
// inner or over the outer radius is dropped. A kept hit runs a bisection
// search for each boundary it crosses (0, 1 or 2 searches, each step two
// interpolations and two squares through the single shared multiplier), then
// its weighted sums are folded in. A hit marked last adds up to four divisions
// on the bit-serial divider, none when the summed weight is zero. The result
// shows for exactly one cycle with done high; the receiver cannot stall it.
// Configuration writes take effect at once and are meant for idle time.
module layer_clipped_weighted_centroid_core
    import lcwc_pkg::*;
#(
    parameter int COORD_BITS    = COORD_BITS_DEF,
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_write,
    input  logic [INDEX_BITS-1:0]        cfg_index,
    input  logic [RADIUS_BITS-1:0]       cfg_data,
    input  logic                         start,
    output logic                         busy,
    input  logic signed [COORD_BITS-1:0] start_x,
    input  logic signed [COORD_BITS-1:0] start_y,
    input  logic signed [COORD_BITS-1:0] start_z,
    input  logic signed [COORD_BITS-1:0] end_x,
    input  logic signed [COORD_BITS-1:0] end_y,
    input  logic signed [COORD_BITS-1:0] end_z,
    input  logic [ENERGY_BITS-1:0]       energy,
    input  logic signed [TIME_BITS-1:0]  mean_time,
    input  logic                         last_hit,
    output logic                         done,
    output logic signed [COORD_BITS-1:0] centroid_x,
    output logic signed [COORD_BITS-1:0] centroid_y,
    output logic signed [COORD_BITS-1:0] centroid_z,
    output logic signed [TIME_BITS-1:0]  centroid_time,
    output logic                         weight_zero
);

    localparam int MW0 = (COORD_BITS + 3 > FRACTION_BITS + 2) ? COORD_BITS + 3
                                                              : FRACTION_BITS + 2;
    localparam int MW  = (MW0 > ENERGY_BITS + 2) ? MW0 : ENERGY_BITS + 2;
    localparam int PW  = 2 * MW;
    localparam int TW  = FRACTION_BITS + 1;
    localparam int SW  = COORD_BITS + 2;
    localparam logic [TW-1:0]        T_ONE = TW'(1) << FRACTION_BITS;
    localparam logic signed [PW-1:0] HALF  = PW'(1) << (FRACTION_BITS - 1);

    lcwc_state_t state_reg, state_next;

    // Configuration
    logic [RADIUS_BITS-1:0] inner_reg, outer_reg;

    // Captured hit
    logic signed [COORD_BITS-1:0] a_reg [3];
    logic signed [COORD_BITS-1:0] b_reg [3];
    logic [ENERGY_BITS-1:0]       energy_reg;
    logic signed [TIME_BITS-1:0]  tval_reg;
    logic                         last_reg;

    // Working registers
    logic signed [COORD_BITS-1:0] p0_reg [3];
    logic signed [COORD_BITS:0]   d_reg [3];
    logic [PW-1:0]                rin2_reg, rout2_reg, rb2_reg, re2_reg, sq_reg, target_reg;
    logic                         need_out_reg, phase_out_reg, tsel_reg, neg_reg;
    logic [TW-1:0]                lo_reg, hi_reg, mid_reg, tin_reg, tout_reg;
    logic signed [COORD_BITS-1:0] px_reg, py_reg;
    logic [ENERGY_BITS-1:0]       w_reg;
    logic signed [SW-1:0]         s_reg;
    logic [1:0]                   ax_reg, fld_reg;
    logic [SUM_BITS-1:0]          sum_reg [4];
    logic [WEIGHT_BITS-1:0]       sw_reg;
    logic signed [PW-1:0]         prod_reg;

    // Result registers
    logic signed [COORD_BITS-1:0] cx_reg, cy_reg, cz_reg;
    logic signed [TIME_BITS-1:0]  ct_reg;
    logic                         wz_reg, done_reg;

    // Combinational helpers
    logic signed [MW-1:0]       op_a, op_b;
    logic signed [PW-1:0]       lerp_v;
    logic [PW-1:0]              prod_u, rsum;
    logic [TW:0]                mid_sum;
    logic [TW-1:0]              mid_c, span, tcur;
    logic                       accept, swap, skip, need_in, need_out, srch_go;
    logic                       div_start, div_done;
    logic [DIV_NUM_BITS-1:0]    div_num, div_q;
    logic [DIV_DEN_BITS-1:0]    div_den;
    logic [SUM_BITS-1:0]        cur_sum, mag;
    logic [SUM_BITS-1:0]        lim, qsat, sval;
    logic                       cur_neg;

    assign accept   = start && (state_reg == ST_IDLE);
    assign prod_u   = PW'(prod_reg);
    assign lerp_v   = (prod_reg + HALF) >>> FRACTION_BITS;
    assign rsum     = sq_reg + prod_u;
    assign swap     = !(rb2_reg < rsum);
    assign skip     = (rb2_reg < rin2_reg && re2_reg < rin2_reg)
                   || (rb2_reg > rout2_reg && re2_reg > rout2_reg);
    assign need_in  = rb2_reg < rin2_reg;
    assign need_out = re2_reg > rout2_reg && rb2_reg < rout2_reg;
    assign mid_sum  = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid_c    = mid_sum[TW:1];
    assign srch_go  = (hi_reg - lo_reg) > TW'(1);
    assign span     = (tout_reg > tin_reg) ? tout_reg - tin_reg : '0;
    assign tcur     = tsel_reg ? tout_reg : tin_reg;

    // Division operands for the current output field
    assign cur_sum = sum_reg[fld_reg];
    assign cur_neg = cur_sum[SUM_BITS-1];
    assign mag     = cur_neg ? (~cur_sum + 1'b1) : cur_sum;
    assign div_den = (fld_reg == 2'd3) ? {1'b0, sw_reg} : {sw_reg, 1'b0};
    assign div_num = mag + SUM_BITS'(div_den >> 1);

    // Saturate the rounded quotient to the field range
    always_comb
    begin
        if (fld_reg == 2'd3)
        begin
            lim = neg_reg ? (SUM_BITS'(1) << (TIME_BITS - 1))
                          : (SUM_BITS'(1) << (TIME_BITS - 1)) - 1'b1;
        end
        else
        begin
            lim = neg_reg ? (SUM_BITS'(1) << (COORD_BITS - 1))
                          : (SUM_BITS'(1) << (COORD_BITS - 1)) - 1'b1;
        end
        qsat = (div_q > lim) ? lim : div_q;
        sval = neg_reg ? (~qsat + 1'b1) : qsat;
    end

    lcwc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_num),
        .divisor  (div_den),
        .done     (div_done),
        .quotient (div_q)
    );

    // Shared multiplier, product registered every cycle
    always_ff @(posedge clk)
    begin
        prod_reg <= op_a * op_b;
    end

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state, multiplier operands and divider launch
    always_comb
    begin
        state_next = state_reg;
        op_a       = '0;
        op_b       = '0;
        div_start  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_RIN;
                end
            end
            ST_RIN:
            begin
                op_a = MW'($signed({1'b0, inner_reg}));
                op_b = MW'($signed({1'b0, inner_reg}));
                state_next = ST_ROUT;
            end
            ST_ROUT:
            begin
                op_a = MW'($signed({1'b0, outer_reg}));
                op_b = MW'($signed({1'b0, outer_reg}));
                state_next = ST_AX;
            end
            ST_AX:
            begin
                op_a = MW'(a_reg[0]);
                op_b = MW'(a_reg[0]);
                state_next = ST_AY;
            end
            ST_AY:
            begin
                op_a = MW'(a_reg[1]);
                op_b = MW'(a_reg[1]);
                state_next = ST_BX;
            end
            ST_BX:
            begin
                op_a = MW'(b_reg[0]);
                op_b = MW'(b_reg[0]);
                state_next = ST_BY;
            end
            ST_BY:
            begin
                op_a = MW'(b_reg[1]);
                op_b = MW'(b_reg[1]);
                state_next = ST_ORD;
            end
            ST_ORD:
            begin
                state_next = ST_CLS;
            end
            ST_CLS:
            begin
                if (skip)
                begin
                    state_next = last_reg ? ST_FIN : ST_IDLE;
                end
                else if (need_in || need_out)
                begin
                    state_next = ST_SRCH;
                end
                else
                begin
                    state_next = ST_SPAN;
                end
            end
            ST_SRCH:
            begin
                if (srch_go)
                begin
                    op_a = MW'(d_reg[0]);
                    op_b = MW'($signed({1'b0, mid_c}));
                    state_next = ST_LX;
                end
                else if (!phase_out_reg && need_out_reg)
                begin
                    state_next = ST_SRCH;
                end
                else
                begin
                    state_next = ST_SPAN;
                end
            end
            ST_LX:
            begin
                op_a = MW'(d_reg[1]);
                op_b = MW'($signed({1'b0, mid_reg}));
                state_next = ST_LY;
            end
            ST_LY:
            begin
                state_next = ST_SQX;
            end
            ST_SQX:
            begin
                op_a = MW'(px_reg);
                op_b = MW'(px_reg);
                state_next = ST_SQY;
            end
            ST_SQY:
            begin
                op_a = MW'(py_reg);
                op_b = MW'(py_reg);
                state_next = ST_CMP;
            end
            ST_CMP:
            begin
                state_next = ST_SRCH;
            end
            ST_SPAN:
            begin
                op_a = MW'($signed({1'b0, energy_reg}));
                op_b = MW'($signed({1'b0, span}));
                state_next = ST_W;
            end
            ST_W:
            begin
                state_next = ST_LRP;
            end
            ST_LRP:
            begin
                op_a = MW'(d_reg[ax_reg]);
                op_b = MW'($signed({1'b0, tcur}));
                state_next = ST_LRA;
            end
            ST_LRA:
            begin
                state_next = tsel_reg ? ST_SW : ST_LRP;
            end
            ST_SW:
            begin
                op_a = MW'(s_reg);
                op_b = MW'($signed({1'b0, w_reg}));
                state_next = ST_SWA;
            end
            ST_SWA:
            begin
                state_next = (ax_reg == 2'd2) ? ST_TW : ST_LRP;
            end
            ST_TW:
            begin
                op_a = MW'(tval_reg);
                op_b = MW'($signed({1'b0, w_reg}));
                state_next = ST_TWA;
            end
            ST_TWA:
            begin
                state_next = last_reg ? ST_FIN : ST_IDLE;
            end
            ST_FIN:
            begin
                state_next = (sw_reg == '0) ? ST_OUT : ST_DIV;
            end
            ST_DIV:
            begin
                div_start  = 1'b1;
                state_next = ST_DWAIT;
            end
            ST_DWAIT:
            begin
                if (div_done)
                begin
                    state_next = (fld_reg == 2'd3) ? ST_OUT : ST_DIV;
                end
            end
            ST_OUT:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers: configuration, accumulators and result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inner_reg <= '0;
            outer_reg <= '1;
            sum_reg   <= '{default: '0};
            sw_reg    <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= (state_reg == ST_OUT);
            if (cfg_write && cfg_index == REG_INNER_RADIUS)
            begin
                inner_reg <= cfg_data;
            end
            if (cfg_write && cfg_index == REG_OUTER_RADIUS)
            begin
                outer_reg <= cfg_data;
            end
            // Fold weighted products into the sums
            if (state_reg == ST_SWA)
            begin
                sum_reg[ax_reg] <= sum_reg[ax_reg] + SUM_BITS'(prod_reg);
            end
            if (state_reg == ST_TWA)
            begin
                sum_reg[3] <= sum_reg[3] + SUM_BITS'(prod_reg);
                sw_reg     <= sw_reg + WEIGHT_BITS'(w_reg);
            end
            // Clear the cluster once its result goes out
            if (state_reg == ST_OUT)
            begin
                sum_reg <= '{default: '0};
                sw_reg  <= '0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    a_reg[0]   <= start_x;
                    a_reg[1]   <= start_y;
                    a_reg[2]   <= start_z;
                    b_reg[0]   <= end_x;
                    b_reg[1]   <= end_y;
                    b_reg[2]   <= end_z;
                    energy_reg <= energy;
                    tval_reg   <= mean_time;
                    last_reg   <= last_hit;
                end
            end
            ST_ROUT:
            begin
                rin2_reg <= prod_u;
            end
            ST_AX:
            begin
                rout2_reg <= prod_u;
            end
            ST_AY, ST_BY, ST_SQY:
            begin
                sq_reg <= prod_u;
            end
            ST_BX:
            begin
                rb2_reg <= rsum;
            end
            ST_ORD:
            begin
                // Order endpoints by squared radius
                for (int i = 0; i < 3; i++)
                begin
                    p0_reg[i] <= swap ? b_reg[i] : a_reg[i];
                    d_reg[i]  <= swap ? (COORD_BITS+1)'(a_reg[i]) - (COORD_BITS+1)'(b_reg[i])
                                      : (COORD_BITS+1)'(b_reg[i]) - (COORD_BITS+1)'(a_reg[i]);
                end
                rb2_reg <= swap ? rsum : rb2_reg;
                re2_reg <= swap ? rb2_reg : rsum;
            end
            ST_CLS:
            begin
                tin_reg       <= '0;
                tout_reg      <= T_ONE;
                lo_reg        <= '0;
                hi_reg        <= T_ONE;
                s_reg         <= '0;
                ax_reg        <= '0;
                tsel_reg      <= 1'b0;
                need_out_reg  <= need_out;
                phase_out_reg <= !need_in;
                target_reg    <= need_in ? rin2_reg : rout2_reg;
            end
            ST_SRCH:
            begin
                if (srch_go)
                begin
                    mid_reg <= mid_c;
                end
                else if (!phase_out_reg)
                begin
                    // Inner crossing found; start the outer search if needed
                    tin_reg       <= hi_reg;
                    phase_out_reg <= 1'b1;
                    target_reg    <= rout2_reg;
                    lo_reg        <= '0;
                    hi_reg        <= T_ONE;
                end
                else
                begin
                    tout_reg <= hi_reg;
                end
            end
            ST_LX:
            begin
                px_reg <= p0_reg[0] + COORD_BITS'(lerp_v);
            end
            ST_LY:
            begin
                py_reg <= p0_reg[1] + COORD_BITS'(lerp_v);
            end
            ST_CMP:
            begin
                if (rsum >= target_reg)
                begin
                    hi_reg <= mid_reg;
                end
                else
                begin
                    lo_reg <= mid_reg;
                end
            end
            ST_W:
            begin
                w_reg <= ENERGY_BITS'(prod_u >> FRACTION_BITS);
            end
            ST_LRA:
            begin
                s_reg    <= s_reg + SW'(p0_reg[ax_reg]) + SW'(lerp_v);
                tsel_reg <= !tsel_reg;
            end
            ST_SWA:
            begin
                s_reg  <= '0;
                ax_reg <= ax_reg + 1'b1;
            end
            ST_FIN:
            begin
                fld_reg <= '0;
                wz_reg  <= (sw_reg == '0);
                cx_reg  <= '0;
                cy_reg  <= '0;
                cz_reg  <= '0;
                ct_reg  <= '0;
            end
            ST_DIV:
            begin
                neg_reg <= cur_neg;
            end
            ST_DWAIT:
            begin
                if (div_done)
                begin
                    case (fld_reg)
                        2'd0:    cx_reg <= COORD_BITS'(sval);
                        2'd1:    cy_reg <= COORD_BITS'(sval);
                        2'd2:    cz_reg <= COORD_BITS'(sval);
                        default: ct_reg <= TIME_BITS'(sval);
                    endcase
                    fld_reg <= fld_reg + 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign busy          = (state_reg != ST_IDLE);
    assign done          = done_reg;
    assign centroid_x    = cx_reg;
    assign centroid_y    = cy_reg;
    assign centroid_z    = cz_reg;
    assign centroid_time = ct_reg;
    assign weight_zero   = wz_reg;

endmodule

// ===== rtl/lcwc_checker.sv =====
// ----------------------------------------------------------------------------
// lcwc_checker
// Port-level checks of the layer clipped weighted centroid core.
// ----------------------------------------------------------------------------
`include "layer_clipped_weighted_centroid_core_macros.svh"

module lcwc_checker
    import lcwc_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input logic                         clk,
    input logic                         rst_n,
    input logic                         start,
    input logic                         busy,
    input logic                         done,
    input logic signed [COORD_BITS-1:0] centroid_x,
    input logic signed [COORD_BITS-1:0] centroid_y,
    input logic signed [COORD_BITS-1:0] centroid_z,
    input logic signed [TIME_BITS-1:0]  centroid_time,
    input logic                         weight_zero
);

    // An accepted transaction keeps the core busy
    `LCWC_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted hit did not raise busy")

    // Results come out only once the core is free again
    `LCWC_ASSERT_IMPLIES(a_done_idle, done, !busy, "result strobe while busy")

    // Each result is a single-cycle strobe
    `LCWC_ASSERT_NEXT(a_done_pulse, done, !done, "result strobe longer than one cycle")

    // A weightless cluster reports zero fields
    `LCWC_ASSERT_IMPLIES(a_zero_fields, done && weight_zero, centroid_x == '0 && centroid_y == '0 && centroid_z == '0 && centroid_time == '0, "nonzero centroid with zero weight")

endmodule

bind layer_clipped_weighted_centroid_core lcwc_checker #(
    .COORD_BITS (COORD_BITS)
) u_lcwc_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .done          (done),
    .centroid_x    (centroid_x),
    .centroid_y    (centroid_y),
    .centroid_z    (centroid_z),
    .centroid_time (centroid_time),
    .weight_zero   (weight_zero)
);

// ===== dv/tb_layer_clipped_weighted_centroid_core.sv =====
// ----------------------------------------------------------------------------
// tb_layer_clipped_weighted_centroid_core
// Self-checking bench for the layer clipped weighted centroid core. Clusters
// of hit transactions are sent under several radius settings. A predictor
// clips each hit to the layer and accumulates the weighted sums. Each
// centroid the block emits is checked field by field against the prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_layer_clipped_weighted_centroid_core;
    import lcwc_pkg::*;

    localparam int CB       = COORD_BITS_DEF;
    localparam int FB       = FRACTION_BITS_DEF;
    localparam longint T1   = longint'(1) << FB;
    localparam int CMAX     = (1 << (CB - 1)) - 1;
    localparam int CMIN     = -(1 << (CB - 1));
    localparam int RMAX     = (1 << RADIUS_BITS) - 1;
    localparam int EMAX     = (1 << ENERGY_BITS) - 1;
    localparam int WDOG_MAX = 20000;
    localparam int SETTLE   = 600;
    localparam logic [INDEX_BITS-1:0] REG_SPARE_A = 2'd2;
    localparam logic [INDEX_BITS-1:0] REG_SPARE_B = 2'd3;

    typedef struct {
        logic signed [CB-1:0]        ax, ay, az, bx, by, bz;
        logic [ENERGY_BITS-1:0]      e;
        logic signed [TIME_BITS-1:0] t;
        logic                        last;
    } hit_t;

    typedef struct {
        logic signed [CB-1:0]        cx, cy, cz;
        logic signed [TIME_BITS-1:0] ct;
        logic                        wz;
    } centroid_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_write = 1'b0;
    logic [INDEX_BITS-1:0] cfg_index = REG_INNER_RADIUS;
    logic [RADIUS_BITS-1:0] cfg_data = '0;
    logic start = 1'b0;
    logic busy;
    logic signed [CB-1:0] start_x = '0, start_y = '0, start_z = '0;
    logic signed [CB-1:0] end_x = '0, end_y = '0, end_z = '0;
    logic [ENERGY_BITS-1:0] energy = '0;
    logic signed [TIME_BITS-1:0] mean_time = '0;
    logic last_hit = 1'b0;
    logic done;
    logic signed [CB-1:0] centroid_x, centroid_y, centroid_z;
    logic signed [TIME_BITS-1:0] centroid_time;
    logic weight_zero;

    // predictor state
    logic [RADIUS_BITS-1:0] layer_inner = '0;
    logic [RADIUS_BITS-1:0] layer_outer = RADIUS_BITS'(RMAX);
    bit [SUM_BITS-1:0]      acc_x, acc_y, acc_z, acc_t;
    bit [WEIGHT_BITS-1:0]   acc_w;

    hit_t      hits_pending[$];
    centroid_t centroids_due[$];
    hit_t      cur_hit;
    int        gap_left = 0;
    bit        no_idle = 0;
    int        errors = 0;
    int        quiet_cycles = 0;

    layer_clipped_weighted_centroid_core u_top (.*);

    always #2 clk = ~clk;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    function automatic longint point_at(longint c0, longint d, longint k);
        longint v;
        v = d * k + (longint'(1) << (FB - 1));
        return c0 + (v >>> FB);
    endfunction

    function automatic longint radius_sq(longint x, longint y);
        return x * x + y * y;
    endfunction

    function automatic longint find_crossing(longint x0, longint y0, longint dx,
                                             longint dy, longint r2);
        longint lo, hi, mid;
        lo = 0;
        hi = T1;
        while (hi - lo > 1) begin
            mid = (lo + hi) >> 1;
            if (radius_sq(point_at(x0, dx, mid), point_at(y0, dy, mid)) >= r2)
                hi = mid;
            else
                lo = mid;
        end
        return hi;
    endfunction

    function automatic bit [63:0] rounded_mean(bit [63:0] num, bit [63:0] den,
                                               int bits);
        bit        neg;
        bit [63:0] mag, q, lim, mask;
        neg  = num[63];
        mag  = neg ? (~num + 64'd1) : num;
        q    = (mag + (den >> 1)) / den;
        lim  = neg ? (64'd1 << (bits - 1)) : ((64'd1 << (bits - 1)) - 64'd1);
        mask = (64'd1 << bits) - 64'd1;
        if (q > lim)
            q = lim;
        return neg ? ((~q + 64'd1) & mask) : (q & mask);
    endfunction

    task automatic fold_hit(hit_t h);
        longint a[3], b[3], p0[3], d[3];
        longint rb2, re2, rin2, rout2, tin, tout, span, w, s;
        centroid_t c;
        bit [63:0] den2;
        a[0] = h.ax; a[1] = h.ay; a[2] = h.az;
        b[0] = h.bx; b[1] = h.by; b[2] = h.bz;
        rin2  = longint'(layer_inner) * longint'(layer_inner);
        rout2 = longint'(layer_outer) * longint'(layer_outer);
        rb2 = radius_sq(a[0], a[1]);
        re2 = radius_sq(b[0], b[1]);
        // order endpoints by transverse radius, swap on a tie
        for (int i = 0; i < 3; i++) begin
            p0[i] = (rb2 < re2) ? a[i] : b[i];
            d[i]  = ((rb2 < re2) ? b[i] : a[i]) - p0[i];
        end
        if (!(rb2 < re2)) begin
            s = rb2; rb2 = re2; re2 = s;
        end
        if (!((rb2 < rin2 && re2 < rin2) || (rb2 > rout2 && re2 > rout2))) begin
            tin  = 0;
            tout = T1;
            if (rb2 < rin2)
                tin = find_crossing(p0[0], p0[1], d[0], d[1], rin2);
            if (re2 > rout2 && rb2 < rout2)
                tout = find_crossing(p0[0], p0[1], d[0], d[1], rout2);
            span = (tout > tin) ? tout - tin : 0;
            w = (longint'(h.e) * span) >>> FB;
            acc_x += 64'(point_at(p0[0], d[0], tin) + point_at(p0[0], d[0], tout)) * 64'(w);
            acc_y += 64'(point_at(p0[1], d[1], tin) + point_at(p0[1], d[1], tout)) * 64'(w);
            acc_z += 64'(point_at(p0[2], d[2], tin) + point_at(p0[2], d[2], tout)) * 64'(w);
            acc_t += 64'(longint'(h.t) * w);
            acc_w += WEIGHT_BITS'(w);
        end
        if (h.last) begin
            if (acc_w == 0) begin
                c = '{cx: '0, cy: '0, cz: '0, ct: '0, wz: 1'b1};
            end else begin
                den2 = 64'(acc_w) << 1;
                c.cx = CB'(rounded_mean(acc_x, den2, CB));
                c.cy = CB'(rounded_mean(acc_y, den2, CB));
                c.cz = CB'(rounded_mean(acc_z, den2, CB));
                c.ct = TIME_BITS'(rounded_mean(acc_t, 64'(acc_w), TIME_BITS));
                c.wz = 1'b0;
            end
            centroids_due.push_back(c);
            acc_x = 0; acc_y = 0; acc_z = 0; acc_t = 0; acc_w = 0;
        end
    endtask

    // ------------------------------------------------------------------
    // Driver: fold in accepted hits, then load the next one after a gap
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        bit took;
        int r;
        if (rst_n) begin
            took = start && !busy;
            if (took) begin
                fold_hit(cur_hit);
                r = $urandom_range(0, 99);
                if (no_idle || r < 50)
                    gap_left = 0;
                else if (r < 92)
                    gap_left = $urandom_range(1, 4);
                else
                    gap_left = $urandom_range(20, 300);
            end
            if (!start || took) begin
                if (gap_left > 0) begin
                    gap_left--;
                    start <= 1'b0;
                end else if (hits_pending.size() > 0) begin
                    cur_hit = hits_pending.pop_front();
                    start_x   <= cur_hit.ax;
                    start_y   <= cur_hit.ay;
                    start_z   <= cur_hit.az;
                    end_x     <= cur_hit.bx;
                    end_y     <= cur_hit.by;
                    end_z     <= cur_hit.bz;
                    energy    <= cur_hit.e;
                    mean_time <= cur_hit.t;
                    last_hit  <= cur_hit.last;
                    start     <= 1'b1;
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: check each centroid against the oldest prediction
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        centroid_t c;
        if (rst_n && done) begin
            if (centroids_due.size() == 0) begin
                $error("unexpected centroid transaction");
                errors++;
            end else begin
                c = centroids_due.pop_front();
                if (centroid_x !== c.cx) begin
                    $error("centroid_x: expected %0d, got %0d", c.cx, centroid_x);
                    errors++;
                end
                if (centroid_y !== c.cy) begin
                    $error("centroid_y: expected %0d, got %0d", c.cy, centroid_y);
                    errors++;
                end
                if (centroid_z !== c.cz) begin
                    $error("centroid_z: expected %0d, got %0d", c.cz, centroid_z);
                    errors++;
                end
                if (centroid_time !== c.ct) begin
                    $error("centroid_time: expected %0d, got %0d", c.ct, centroid_time);
                    errors++;
                end
                if (weight_zero !== c.wz) begin
                    $error("weight_zero: expected %0d, got %0d", c.wz, weight_zero);
                    errors++;
                end
            end
        end
    end

    // Watchdog: count cycles with no transaction in either direction
    always @(posedge clk) begin
        if ((start && !busy) || done)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WDOG_MAX) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    function automatic void add_hit(int ax, int ay, int az, int bx, int by, int bz,
                                    int e, int t, bit last);
        hit_t h;
        h = '{ax: CB'(ax), ay: CB'(ay), az: CB'(az), bx: CB'(bx), by: CB'(by),
              bz: CB'(bz), e: ENERGY_BITS'(e), t: TIME_BITS'(t), last: last};
        hits_pending.push_back(h);
    endfunction

    task automatic write_reg(logic [INDEX_BITS-1:0] idx, int val);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= RADIUS_BITS'(val);
        if (idx == REG_INNER_RADIUS)
            layer_inner = RADIUS_BITS'(val);
        else if (idx == REG_OUTER_RADIUS)
            layer_outer = RADIUS_BITS'(val);
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    // hold until every hit is folded in and the block has settled
    task automatic drain();
        while (hits_pending.size() > 0 || start || centroids_due.size() > 0 || busy)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // coordinate near the current layer, or anywhere in range
    function automatic int pick_coord();
        int scale;
        scale = ((layer_outer > layer_inner) ? layer_outer : layer_inner) * 5 / 4 + 64;
        if (scale > CMAX)
            scale = CMAX;
        if ($urandom_range(0, 3) == 0)
            return int'($signed(CB'($urandom)));
        return int'($urandom_range(0, 2 * scale)) - scale;
    endfunction

    function automatic int pick_energy();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0)
            return 0;
        if (r == 1)
            return EMAX;
        if (r < 6)
            return $urandom_range(0, 255);
        return $urandom_range(0, EMAX);
    endfunction

    task automatic random_clusters(int n_hits);
        int len;
        while (n_hits > 0) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 20)
                                              : $urandom_range(1, 5);
            for (int i = 0; i < len; i++)
                add_hit(pick_coord(), pick_coord(), pick_coord(), pick_coord(),
                        pick_coord(), pick_coord(), pick_energy(),
                        int'($signed(16'($urandom))), i == len - 1);
            n_hits -= len;
        end
    endtask

    initial begin
        int inner_set[6] = '{0, 100000, 1000, 300000, 0, 200000};
        int outer_set[6] = '{RMAX, 300000, 3000, 100000, 0, RMAX};

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // field extremes under the reset layer
        write_reg(REG_INNER_RADIUS, 0);
        write_reg(REG_OUTER_RADIUS, RMAX);
        write_reg(REG_SPARE_A, RMAX);
        write_reg(REG_SPARE_B, 12345);
        add_hit(CMAX, CMAX, CMAX, CMIN, CMIN, CMIN, EMAX, 32767, 0);
        add_hit(CMIN, 0, CMIN, 0, CMAX, CMAX, EMAX, -32768, 0);
        add_hit(1, -1, 0, -5000, 7000, 9, 1, 0, 1);
        add_hit(CMAX, CMIN, CMAX, CMIN, CMAX, CMIN, EMAX, 32767, 1);
        // zero weight cluster
        add_hit(10, 20, 30, 40, 50, 60, 0, 100, 0);
        add_hit(-10, 20, 30, 40, -50, 60, 0, -100, 1);
        drain();

        // layer cases: inside, outside, crossing, on the circle, tie
        write_reg(REG_INNER_RADIUS, 100000);
        write_reg(REG_OUTER_RADIUS, 300000);
        add_hit(1000, 2000, 5, -3000, 4000, 7, 5000, 50, 1);
        add_hit(400000, 0, 5, 0, -400000, 7, 5000, 50, 1);
        add_hit(50000, 10000, -200, 350000, -20000, 900, 70000, -321, 0);
        add_hit(300000, 0, 0, 450000, 1000, 10, 65536, 77, 0);
        add_hit(120000, 160000, 3, -160000, -120000, 99, 4096, 12, 0);
        add_hit(0, 200000, -5, 200000, 0, 5, 9999, -1, 1);
        add_hit(10, 10, 10, 500000, 500000, 0, EMAX, 32767, 1);
        drain();

        // inner above outer: no weight at all
        write_reg(REG_INNER_RADIUS, 300000);
        write_reg(REG_OUTER_RADIUS, 100000);
        add_hit(0, 0, 0, 250000, 0, 0, 1000, 5, 0);
        add_hit(-50000, 90000, 1, 200000, -10, 2, EMAX, 6, 1);
        drain();

        // random clusters under each layer setting
        for (int p = 0; p < 6; p++) begin
            write_reg(REG_INNER_RADIUS, inner_set[p]);
            write_reg(REG_OUTER_RADIUS, outer_set[p]);
            no_idle = (p % 3 == 1);
            random_clusters(185);
            drain();
        end

        if (centroids_due.size() != 0) begin
            $error("%0d centroid transactions never arrived", centroids_due.size());
            errors++;
        end
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
